// File: rtl/blbfs_pkg.sv
package blbfs_pkg;

  // fixed graph geometry
  localparam int ROWS   = 32;
  localparam int NODE_W = 5;

  // register indexes on the configuration port
  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_START_NODE = 2'd1;
  localparam logic [1:0] REG_BEAM_WIDTH = 2'd2;

  // request kinds
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // microprogram step addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_CHECK = 3'd1;
  localparam step_t ST_BAD   = 3'd2;
  localparam step_t ST_DEQ   = 3'd3;
  localparam step_t ST_PICK  = 3'd4;
  localparam step_t ST_FIN   = 3'd5;

  // branch conditions
  typedef enum logic [2:0] {
    C_NEVER = 3'd0,
    C_RUN   = 3'd1,
    C_BAD   = 3'd2,
    C_EMPTY = 3'd3,
    C_PDONE = 3'd4
  } cond_t;

  // one control word
  typedef struct packed {
    logic  in_rdy;
    logic  init;
    logic  deq;
    logic  pick;
    logic  emit_bad;
    logic  emit_fin;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic run;
    logic bad;
    logic empty;
    logic pdone;
    logic hold;
  } stat_t;

  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    w = '{in_rdy: 1'b0, init: 1'b0, deq: 1'b0, pick: 1'b0, emit_bad: 1'b0,
          emit_fin: 1'b0, cond: C_NEVER, t_true: ST_IDLE, t_false: ST_IDLE};
    case (pc)
      ST_IDLE: begin
        w.in_rdy = 1'b1; w.cond = C_RUN; w.t_true = ST_CHECK; w.t_false = ST_IDLE;
      end
      ST_CHECK: begin
        w.init = 1'b1; w.cond = C_BAD; w.t_true = ST_BAD; w.t_false = ST_DEQ;
      end
      ST_BAD: begin
        w.emit_bad = 1'b1; w.cond = C_NEVER; w.t_false = ST_IDLE;
      end
      ST_DEQ: begin
        w.deq = 1'b1; w.cond = C_EMPTY; w.t_true = ST_FIN; w.t_false = ST_PICK;
      end
      ST_PICK: begin
        w.pick = 1'b1; w.cond = C_PDONE; w.t_true = ST_DEQ; w.t_false = ST_PICK;
      end
      ST_FIN: begin
        w.emit_fin = 1'b1; w.cond = C_NEVER; w.t_false = ST_IDLE;
      end
      default: begin
        w.cond = C_NEVER; w.t_false = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/blbfs_seq.sv
module blbfs_seq
  import blbfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctl_t  ctl
);

  step_t pc_r, pc_nxt;
  logic  cond_hit;

  assign ctl = ucode(pc_r);

  always_comb begin
    case (ctl.cond)
      C_NEVER: cond_hit = 1'b0;
      C_RUN:   cond_hit = stat.run;
      C_BAD:   cond_hit = stat.bad;
      C_EMPTY: cond_hit = stat.empty;
      C_PDONE: cond_hit = stat.pdone;
      default: cond_hit = 1'b0;
    endcase
  end

  // a stalled emit holds the step
  always_comb begin
    if (stat.hold) pc_nxt = pc_r;
    else if (cond_hit) pc_nxt = ctl.t_true;
    else pc_nxt = ctl.t_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= ST_IDLE;
    else pc_r <= pc_nxt;
  end

endmodule

// File: rtl/blbfs_dp.sv
module blbfs_dp
  import blbfs_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tuser,
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic        out_tuser
);

  localparam int         CAP     = (MAX_NODES < ROWS) ? MAX_NODES : ROWS;
  localparam logic [5:0] LIM_CAP = 6'(CAP);

  logic [5:0]        node_count_r, start_node_ext, beam_width_r;
  logic [4:0]        start_node_r;
  logic [ROWS-1:0]   adj_r [ROWS];
  logic [NODE_W-1:0] fifo_r [ROWS];
  logic [ROWS-1:0]   visited_r, row_r, cand, lim_mask;
  logic [5:0]        head_r, tail_r, taken_r, lim;
  logic [4:0]        pend_r, pick_idx, cur;
  logic              out_valid_r, out_last_r, out_bad_r;
  logic [4:0]        out_node_r;
  logic              accept, out_busy, need_out, do_pick;

  assign start_node_ext = {1'b0, start_node_r};
  assign lim = (node_count_r > LIM_CAP) ? LIM_CAP : node_count_r;

  always_comb begin
    for (int i = 0; i < ROWS; i++) lim_mask[i] = (6'(i) < lim);
  end

  assign cand = row_r & ~visited_r;

  // lowest unvisited neighbour
  always_comb begin
    pick_idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (cand[i]) pick_idx = 5'(i);
    end
  end

  assign accept   = in_tvalid && ctl.in_rdy;
  assign out_busy = out_valid_r && !out_tready;
  assign do_pick  = ctl.pick && (cand != '0);
  assign need_out = do_pick || ctl.emit_bad || ctl.emit_fin;
  assign cur      = fifo_r[head_r[4:0]];

  assign stat.run   = accept && (in_tuser == OP_RUN);
  assign stat.bad   = start_node_ext >= lim;
  assign stat.empty = head_r == tail_r;
  assign stat.pdone = (cand == '0) || ((7'(taken_r) + 7'd1) >= 7'(beam_width_r));
  assign stat.hold  = need_out && out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 6'd32;
      start_node_r <= 5'd0;
      beam_width_r <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count_r <= cfg_wdata;
        REG_START_NODE: start_node_r <= cfg_wdata[4:0];
        REG_BEAM_WIDTH: beam_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) adj_r[i] <= '0;
    end else if (accept && (in_tuser == OP_LOAD)) begin
      adj_r[in_tdata[4:0]] <= in_tdata[36:5];
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      taken_r   <= '0;
    end else if (!stat.hold) begin
      if (ctl.init) begin
        visited_r <= ROWS'(1) << start_node_r;
        head_r    <= '0;
        tail_r    <= 6'd1;
        fifo_r[0] <= start_node_r;
        pend_r    <= start_node_r;
      end
      if (ctl.deq && !stat.empty) begin
        head_r  <= head_r + 6'd1;
        taken_r <= '0;
        row_r   <= (beam_width_r == '0) ? '0 : (adj_r[cur] & lim_mask);
      end
      if (do_pick) begin
        visited_r <= visited_r | (ROWS'(1) << pick_idx);
        pend_r    <= pick_idx;
        taken_r   <= taken_r + 6'd1;
        if (!tail_r[5]) begin
          fifo_r[tail_r[4:0]] <= pick_idx;
          tail_r <= tail_r + 6'd1;
        end
      end
    end
  end

  // output register, one result held back until the next or the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (need_out && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (need_out && !out_busy) begin
      out_node_r <= ctl.emit_bad ? 5'd0 : pend_r;
      out_last_r <= ctl.emit_bad || ctl.emit_fin;
      out_bad_r  <= ctl.emit_bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_node_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

endmodule

// File: rtl/beam_limited_bfs_order.sv
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   tuser operation, tdata row_index, row_bits
// out_      out  out_tvalid/out_tready tdata node, tlast last, tuser bad_start
// cfg_      in   cfg_we                cfg_index, cfg_wdata
//
// load: taken in the idle step; bad start: idle, check, bad; run: idle, check, then
// per queued node a dequeue step and its pick steps (one per neighbour taken, plus an
// empty pick when the scan ends on no candidate), a last dequeue on the empty queue, fin
// reset (synchronous, rst_n low) clears the adjacency rows, the search state and the
// output register and puts node_count 32, start_node 0, beam_width 1
// a stalled output holds the sequencer on its emit step; input waits for the idle step
module beam_limited_bfs_order
  import blbfs_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row_index [4:0], row_bits [36:5], zero fill
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // node [4:0], zero fill
  output logic        out_tlast,
  output logic        out_tuser   // bad_start
);

  ctl_t  ctl;
  stat_t stat;

  // sequencer: step counter plus control-word rom
  blbfs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // datapath: adjacency rows, visited map, node queue, neighbour pick
  blbfs_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // requests are taken only in the idle step
  assign in_tready = ctl.in_rdy;

endmodule

// File: rtl/blbfs_chk.sv
module blbfs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // a bad start always closes its run
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("bad start result without last");

  // a bad start result carries node zero
  a_bad_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0)
    else $error("bad start result with nonzero node");

  // node field padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] == 3'd0)
    else $error("output padding not zero");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind beam_limited_bfs_order blbfs_chk u_chk (.*);

// File: tb/sv/tb_beam_limited_bfs_order.sv
module tb_beam_limited_bfs_order;
  import blbfs_pkg::*;

  // the block is built with its default node bound
  localparam int DUT_MAX_NODES = 32;
  // idle this long after the last owed visit before a register write
  localparam int SETTLE_CYCLES = 2 * ROWS + 16;
  // slowest run: ~155 requests, each with up to 32 results, plus random stalls, gaps and hold
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_REQUESTS = 125;

  // one visit reported by the block
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              bad_start;
  } visit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_NODE_COUNT;
  logic [5:0]  cfg_wdata = 6'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = 40'd0;   // row_index [4:0], row_bits [36:5], zero fill
  logic        in_tuser = OP_LOAD; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;          // node [4:0], zero fill
  logic        out_tlast;
  logic        out_tuser;          // bad_start

  // shadow of the block: adjacency rows and the three registers
  logic [31:0] adj_model [ROWS];
  logic [5:0]  model_node_count;
  logic [4:0]  model_start;
  logic [5:0]  model_beam;

  // visits the block still owes us, oldest first
  visit_t pending_visits [$];

  int cycle_count = 0;
  int error_count = 0;
  int request_count = 0;
  int search_count = 0;
  int visits_checked = 0;
  int setting_count = 0;
  int hold_count = 0;

  // idling knobs, changed per phase so some stretches run back to back
  int send_gap_max = 16;
  int sink_gap_max = 16;
  // long receiver hold, picked up by the sink process
  int sink_hold_cycles = 0;

  always #1 clk = ~clk;

  beam_limited_bfs_order #(.MAX_NODES(DUT_MAX_NODES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(input string msg);
    error_count++;
    // keep the log short on a badly broken block
    if (error_count <= 40) $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // breadth-first order with at most model_beam new neighbours per expanded node
  function automatic void predict_search(input logic op, input logic [4:0] row,
                                         input logic [31:0] bits);
    int         lim;
    int         taken;
    int         j;
    logic [31:0] seen;
    logic [4:0] bfs_q [$];
    logic [4:0] cur;
    visit_t     v;
    if (op == OP_LOAD) begin
      adj_model[row] = bits;
      return;
    end
    lim = model_node_count;
    if (lim > DUT_MAX_NODES) lim = DUT_MAX_NODES;
    if (lim > ROWS) lim = ROWS;
    // start outside the graph: one flagged visit and nothing else
    if (model_start >= lim) begin
      v = '{node: '0, last: 1'b1, bad_start: 1'b1};
      pending_visits.push_back(v);
      return;
    end
    seen = '0;
    seen[model_start] = 1'b1;
    v = '{node: model_start, last: 1'b0, bad_start: 1'b0};
    pending_visits.push_back(v);
    bfs_q.push_back(model_start);
    while (bfs_q.size() > 0) begin
      cur = bfs_q.pop_front();
      taken = 0;
      // beam of zero takes nothing; the scan ends once the beam is full
      for (j = 0; j < lim && taken < model_beam; j++) begin
        if (adj_model[cur][j] && !seen[j]) begin
          seen[j] = 1'b1;
          v = '{node: j[4:0], last: 1'b0, bad_start: 1'b0};
          pending_visits.push_back(v);
          bfs_q.push_back(j[4:0]);
          taken++;
        end
      end
    end
    pending_visits[pending_visits.size() - 1].last = 1'b1;
  endfunction

  // one request on the input channel; valid stays high after acceptance so a
  // back-to-back request never drops it within a step
  task automatic send_request(input logic op, input logic [4:0] row, input logic [31:0] bits);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, bits, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // taken at this edge
    predict_search(op, row, bits);
    request_count++;
    if (op == OP_RUN) search_count++;
  endtask

  task automatic load_row(input logic [4:0] row, input logic [31:0] bits);
    send_request(OP_LOAD, row, bits);
  endtask

  task automatic run_search();
    logic [4:0]  row;
    logic [31:0] bits;
    // row and bits mean nothing to a run; keep them random
    row  = 5'($urandom);
    bits = $urandom;
    send_request(OP_RUN, row, bits);
  endtask

  // let every owed visit arrive and the sequencer fall back to idle
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all three registers back to back; start_node may carry a junk top bit
  task automatic set_config(input logic [5:0] node_count, input logic [4:0] start,
                            input logic [5:0] beam);
    logic pad;
    pad = 1'($urandom_range(0, 1));
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= REG_NODE_COUNT;
    cfg_wdata <= node_count;
    @(posedge clk);
    model_node_count = node_count;
    cfg_index <= REG_START_NODE;
    cfg_wdata <= {pad, start};
    @(posedge clk);
    model_start = start;
    cfg_index <= REG_BEAM_WIDTH;
    cfg_wdata <= beam;
    @(posedge clk);
    model_beam = beam;
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus a long hold when a test asks for one
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        out_tready <= 1'b0;
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
        repeat (stall) @(posedge clk);
        hold_count++;
      end
      stall = $urandom_range(0, sink_gap_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // every accepted visit against the oldest one owed
  always @(posedge clk) begin : visit_check
    visit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected visit node %0d last %0b bad_start %0b",
                                  out_tdata[NODE_W-1:0], out_tlast, out_tuser));
      end else begin
        want = pending_visits.pop_front();
        visits_checked++;
        if (out_tdata[NODE_W-1:0] !== want.node)
          report_mismatch($sformatf("node %0d, want %0d", out_tdata[NODE_W-1:0], want.node));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b, want %0b (node %0d)",
                                    out_tlast, want.last, want.node));
        if (out_tuser !== want.bad_start)
          report_mismatch($sformatf("bad_start %0b, want %0b (node %0d)",
                                    out_tuser, want.bad_start, want.node));
      end
    end
  end

  // hang guard
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timed out with %0d visits still owed", pending_visits.size());
    $display("tb_beam_limited_bfs_order: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // reset registers and empty rows: a lone start visit
  task automatic test_reset_defaults();
    run_search();
  endtask

  // extreme rows, then full fan-out for the longest possible runs
  task automatic test_row_extremes();
    load_row(5'd0, 32'hFFFF_FFFF);
    load_row(5'd31, 32'h8000_0001);
    load_row(5'd1, 32'h0000_0000);
    set_config(6'd32, 5'd0, 6'd32);
    run_search();
    set_config(6'd32, 5'd31, 6'd63);
    run_search();
  endtask

  // beam of zero, one, and far past the node count
  task automatic test_beam_extremes();
    set_config(6'd32, 5'd0, 6'd0);
    run_search();
    set_config(6'd32, 5'd0, 6'd1);
    run_search();
    set_config(6'd63, 5'd31, 6'd63);
    run_search();
  endtask

  // smallest graphs and a count clipped to the node bound
  task automatic test_node_count_extremes();
    set_config(6'd1, 5'd0, 6'd32);
    run_search();
    set_config(6'd2, 5'd1, 6'd32);
    load_row(5'd1, 32'h0000_0003);
    run_search();
    set_config(6'd63, 5'd30, 6'd2);
    run_search();
  endtask

  // start at or past the count, count zero; a good run after shows nothing leaked
  task automatic test_bad_start();
    set_config(6'd5, 5'd5, 6'd3);
    run_search();
    set_config(6'd0, 5'd0, 6'd3);
    run_search();
    set_config(6'd31, 5'd31, 6'd32);
    run_search();
    load_row(5'd30, 32'h4000_0001);
    set_config(6'd1, 5'd1, 6'd1);
    run_search();
    set_config(6'd31, 5'd30, 6'd32);
    run_search();
  endtask

  // receiver holds off while the sender keeps offering runs and loads
  task automatic test_output_backpressure();
    set_config(6'd32, 5'd0, 6'd32);
    send_gap_max = 0;
    sink_gap_max = 0;
    sink_hold_cycles = 400;
    run_search();
    run_search();
    load_row(5'd2, 32'h0000_F00F);
    run_search();
    send_gap_max = 16;
    sink_gap_max = 16;
  endtask

  // ---------------------------------------------------------------------------
  // random graphs: per phase a setting, some row loads, then a few runs
  // ---------------------------------------------------------------------------
  task automatic test_random_graphs();
    int          sent;
    int          lim;
    int          loads;
    int          runs;
    int          k;
    logic [5:0]  nc;
    logic [4:0]  start;
    logic [5:0]  beam;
    logic [4:0]  row;
    logic [31:0] bits;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0:       nc = 6'd1;
        1:       nc = 6'd32;
        2:       nc = 6'($urandom_range(33, 63));
        3:       nc = 6'd0;
        default: nc = 6'($urandom_range(2, 32));
      endcase
      lim = (nc > ROWS) ? ROWS : nc;
      if (lim == 0 || $urandom_range(0, 7) == 0) start = 5'($urandom_range(0, 31));
      else start = 5'($urandom_range(0, lim - 1));
      case ($urandom_range(0, 9))
        0:       beam = 6'd0;
        1:       beam = 6'd1;
        2:       beam = 6'd32;
        3:       beam = 6'd63;
        4:       beam = 6'($urandom_range(33, 62));
        default: beam = 6'($urandom_range(1, 6));
      endcase
      set_config(nc, start, beam);
      // vary idling per phase, with some phases running flat out
      case ($urandom_range(0, 3))
        0:       begin send_gap_max = 0;  sink_gap_max = 0;  end
        1:       begin send_gap_max = 16; sink_gap_max = 0;  end
        2:       begin send_gap_max = 0;  sink_gap_max = 16; end
        default: begin send_gap_max = 16; sink_gap_max = 16; end
      endcase
      loads = $urandom_range(1, 6);
      for (k = 0; k < loads; k++) begin
        if (lim == 0 || $urandom_range(0, 5) == 0) row = 5'($urandom_range(0, 31));
        else row = 5'($urandom_range(0, lim - 1));
        case ($urandom_range(0, 5))
          0:       bits = 32'hFFFF_FFFF;
          1:       bits = 32'h0000_0000;
          2:       bits = $urandom;
          default: bits = $urandom & $urandom & $urandom;  // sparse rows give deep walks
        endcase
        load_row(row, bits);
        sent++;
      end
      runs = $urandom_range(1, 3);
      for (k = 0; k < runs; k++) begin
        run_search();
        sent++;
      end
    end
    send_gap_max = 16;
    sink_gap_max = 16;
  endtask

  initial begin : main_sequence
    int r;
    for (r = 0; r < ROWS; r++) adj_model[r] = '0;
    model_node_count = 6'd32;
    model_start      = 5'd0;
    model_beam       = 6'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_row_extremes();
    test_beam_extremes();
    test_node_count_extremes();
    test_bad_start();
    test_output_backpressure();
    test_random_graphs();

    // drain everything owed, then give the sequencer time to go idle
    settle_block();

    $display("tb: %0d requests (%0d searches) over %0d register settings",
             request_count, search_count, setting_count);
    $display("tb: %0d visits checked, %0d long output holds, %0d mismatches",
             visits_checked, hold_count, error_count);
    if (error_count == 0) begin
      $display("tb_beam_limited_bfs_order: clean");
    end else begin
      $display("tb_beam_limited_bfs_order: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/blbfs_pkg.sv
rtl/blbfs_seq.sv
rtl/blbfs_dp.sv
rtl/beam_limited_bfs_order.sv
rtl/blbfs_chk.sv
tb/sv/tb_beam_limited_bfs_order.sv
